FILE: src/plcr_pkg.sv
// ---------------------------------------------------------------------------
// plcr_pkg: shared types and constants of the piecewise linear colour ramp
// Knot packing, reset values, queue item layout and the reciprocal table
// used by the blend pipeline.
// ---------------------------------------------------------------------------
package plcr_pkg;

  // Knot register file
  localparam int KNOT_REGS  = 6;
  localparam int KNOT_SLOTS = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CHAN_N     = 3;

  // Field positions inside one knot word
  localparam int POS_LSB = 24;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic [31:0] KNOT_RESET [KNOT_SLOTS] = '{
    32'h0000_0000, 32'h2800_FF00, 32'h38FF_FF00, 32'h48FF_8000,
    32'h80FF_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF
  };

  // Queue between classifier and blend pipeline
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Reciprocal of the segment span, scaled by 2^RECIP_SHIFT
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int SPAN_N      = 256;

  typedef logic [RECIP_W-1:0] recip_t;
  typedef recip_t recip_tab_t [SPAN_N];

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
  } cfg_wr_t;

  typedef struct packed {
    logic [CHAN_N-1:0][7:0] c0;
    logic [CHAN_N-1:0][7:0] c1;
    logic [7:0]             t;
    logic [7:0]             d;
    logic                   beyond;
  } plcr_item_t;

  // Build floor(2^RECIP_SHIFT / d) by restoring long division
  function automatic recip_tab_t build_recip_tab();
    recip_tab_t        tab;
    logic [RECIP_W:0]  rem;
    logic [RECIP_W-1:0] quo;
    for (int i = 0; i < SPAN_N; i++) begin
      rem = '0;
      quo = '0;
      for (int b = RECIP_W - 1; b >= 0; b--) begin
        rem = {rem[RECIP_W-1:0], (b == RECIP_SHIFT)};
        if (i != 0 && rem >= (RECIP_W + 1)'(i)) begin
          rem    = rem - (RECIP_W + 1)'(i);
          quo[b] = 1'b1;
        end
      end
      tab[i] = quo;
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP_TAB = build_recip_tab();

endpackage

FILE: src/piecewise_linear_color_ramp_top.sv
// ---------------------------------------------------------------------------
// piecewise_linear_color_ramp_top: level to RGBA colour ramp
// Interpolates an 8-bit level between up to eight knots of position and RGB.
// ---------------------------------------------------------------------------
// Usage
//   Input: drive level_i and raise start_i; the level is taken at a rising
//   edge where start_i is high and busy_o is low. A new level may follow
//   every cycle.
//   Output: each colour appears on red_o, green_o, blue_o, alpha_o and
//   beyond_last_o for exactly one cycle, marked by valid_o, after the queue
//   and the blend stages. Results leave in the order levels came in.
//   Throughput is one level per cycle, set by the five-stage blend pipeline
//   with one reciprocal multiply and one remainder multiply per channel.
//   busy_o is the two-entry queue being full, which never happens: the
//   blend pipeline takes a beat every cycle, so busy_o stays low.
//   Configuration: knot registers 0 to 5 are written through cfg_valid_i,
//   cfg_index_i and cfg_data_i; cfg_ready_o is always high. Indexes 6 and 7
//   are dropped. Write only while no level is in flight.
//   Reset: rst_ni low clears the queue and pipeline and loads the default
//   ramp; the receiver cannot stall, so no result is ever held back.
// ---------------------------------------------------------------------------
module piecewise_linear_color_ramp_top import plcr_pkg::*; #(
  parameter int LEVEL_COUNT = 256,
  parameter int KNOT_COUNT  = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [7:0]           level_i,
  output logic                 valid_o,
  output logic [7:0]           red_o,
  output logic [7:0]           green_o,
  output logic [7:0]           blue_o,
  output logic [7:0]           alpha_o,
  output logic                 beyond_last_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  cfg_wr_t    cfg_wr;
  plcr_item_t front_item, queue_item;
  logic       push, full, q_valid, pop;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr.en   = cfg_valid_i;
  assign cfg_wr.idx  = cfg_index_i;
  assign cfg_wr.data = cfg_data_i;

  plcr_front #(
    .LEVEL_COUNT(LEVEL_COUNT),
    .KNOT_COUNT (KNOT_COUNT)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_wr_i(cfg_wr),
    .start_i (start_i),
    .level_i (level_i),
    .full_i  (full),
    .push_o  (push),
    .item_o  (front_item)
  );

  plcr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .full_o (full),
    .valid_o(q_valid),
    .item_o (queue_item)
  );

  plcr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .item_i  (queue_item),
    .pop_o   (pop),
    .valid_o (valid_o),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o),
    .beyond_o(beyond_last_o)
  );

  assign busy_o  = full;
  assign alpha_o = ALPHA_OPAQUE;

endmodule

FILE: src/plcr_front.sv
// ---------------------------------------------------------------------------
// plcr_front: knot registers and segment classifier
// Holds the knot file, picks the segment for each accepted level and pushes
// the blend operands into the queue.
// ---------------------------------------------------------------------------
module plcr_front import plcr_pkg::*; #(
  parameter int LEVEL_COUNT = 256,
  parameter int KNOT_COUNT  = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_wr_t    cfg_wr_i,
  input  logic       start_i,
  input  logic [7:0] level_i,
  input  logic       full_i,
  output logic       push_o,
  output plcr_item_t item_o
);

  localparam int KN = (KNOT_COUNT < 2) ? 2 : ((KNOT_COUNT > KNOT_SLOTS) ? KNOT_SLOTS : KNOT_COUNT);
  localparam int LVL_MAX_I = (LEVEL_COUNT > 256) ? 255 : LEVEL_COUNT - 1;
  localparam logic [7:0] LVL_MAX = 8'(LVL_MAX_I);

  logic [31:0] knot_q [KNOT_REGS];
  logic [31:0] slot [KNOT_SLOTS];
  logic [31:0] nxt_slot [KNOT_SLOTS];
  logic [7:0]  pos [KNOT_SLOTS];
  logic [7:0]  nxt_pos [KNOT_SLOTS];

  logic [7:0]            lvl;
  logic [KNOT_SLOTS-1:0] sel;
  logic                  found;
  logic                  is_last;
  logic                  exact;
  logic [7:0]            p0, p1;
  logic [31:0]           w0, w1;

  // Write the knot file; indexes past the last register are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KNOT_REGS; i++) knot_q[i] <= KNOT_RESET[i];
    end else if (cfg_wr_i.en && cfg_wr_i.idx < CFG_IDX_W'(KNOT_REGS)) begin
      knot_q[cfg_wr_i.idx] <= cfg_wr_i.data;
    end
  end

  // Slots without a register read as their fixed white knot
  for (genvar g = 0; g < KNOT_SLOTS; g++) begin : g_slot
    if (g < KNOT_REGS) begin : g_reg
      assign slot[g] = knot_q[g];
    end else begin : g_fix
      assign slot[g] = KNOT_RESET[g];
    end
    if (g == 0) begin : g_zero
      assign pos[g] = 8'd0;
    end else begin : g_pos
      assign pos[g] = slot[g][POS_LSB +: 8];
    end
  end

  for (genvar g = 0; g < KNOT_SLOTS; g++) begin : g_nxt
    if (g < KNOT_SLOTS - 1) begin : g_up
      assign nxt_slot[g] = slot[g+1];
      assign nxt_pos[g]  = pos[g+1];
    end else begin : g_top
      assign nxt_slot[g] = slot[g];
      assign nxt_pos[g]  = pos[g];
    end
  end

  // Saturate the level to the ramp length
  assign lvl = (level_i > LVL_MAX) ? LVL_MAX : level_i;

  // Select the highest knot whose position is not above the level
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = KNOT_SLOTS - 1; i >= 0; i--) begin
      if (i < KN && pos[i] <= lvl && !found) begin
        sel[i] = 1'b1;
        found  = 1'b1;
      end
    end
  end

  // Gather segment end points with an and-or mux
  always_comb begin
    p0      = '0;
    p1      = '0;
    w0      = '0;
    w1      = '0;
    is_last = 1'b0;
    for (int i = 0; i < KNOT_SLOTS; i++) begin
      if (sel[i]) begin
        p0 = p0 | pos[i];
        p1 = p1 | nxt_pos[i];
        w0 = w0 | slot[i];
        w1 = w1 | nxt_slot[i];
        if (i == KN - 1) is_last = 1'b1;
      end
    end
  end

  // Exact hits and the tail become a blend with zero weight on the far knot
  always_comb begin
    exact              = (lvl == p0);
    item_o.beyond      = !exact && is_last;
    for (int s = 0; s < CHAN_N; s++) begin
      item_o.c0[s] = w0[16 - 8 * s +: 8];
      item_o.c1[s] = w1[16 - 8 * s +: 8];
    end
    if (!exact && !is_last) begin
      item_o.t = lvl - p0;
      item_o.d = p1 - p0;
    end else begin
      item_o.t = 8'd0;
      item_o.d = 8'd1;
    end
  end

  assign push_o = start_i && !full_i;

endmodule

FILE: src/plcr_queue.sv
// ---------------------------------------------------------------------------
// plcr_queue: short item queue
// Two-entry FIFO that decouples the classifier from the blend pipeline.
// ---------------------------------------------------------------------------
module plcr_queue import plcr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  plcr_item_t item_i,
  input  logic       pop_i,
  output logic       full_o,
  output logic       valid_o,
  output plcr_item_t item_o
);

  plcr_item_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_W'(do_push);
    rd_ptr_d = rd_ptr_q + QPTR_W'(do_pop);
    cnt_d    = cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

FILE: src/plcr_back.sv
// ---------------------------------------------------------------------------
// plcr_back: blend pipeline
// Five stages: weighted sum, reciprocal multiply, remainder, quotient
// correction, round to nearest with ties to even.
// ---------------------------------------------------------------------------
module plcr_back import plcr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  plcr_item_t item_i,
  output logic       pop_o,
  output logic       valid_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic       beyond_o
);

  // Stage valids
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // Stage payloads
  logic [CHAN_N-1:0][15:0] num1_q, num1_d, num2_q, num2_d;
  logic [CHAN_N-1:0][7:0]  q2_q, q2_d, q3_q, q3_d, q4_q, q4_d, q5_q, q5_d;
  logic [CHAN_N-1:0][8:0]  r3_q, r3_d;
  logic [CHAN_N-1:0][7:0]  r4_q, r4_d;
  recip_t                  recip1_q, recip1_d;
  logic [7:0]              d1_q, d2_q, d3_q, d4_q;
  logic                    b1_q, b2_q, b3_q, b4_q, b5_q;

  logic [7:0] w_near;

  assign pop_o = valid_i;

  // Stage 1: weighted sum c0*(d-t) + c1*t, reciprocal lookup
  always_comb begin
    logic [15:0] pa, pb;
    logic [16:0] sum;
    w_near   = item_i.d - item_i.t;
    recip1_d = RECIP_TAB[item_i.d];
    for (int s = 0; s < CHAN_N; s++) begin
      pa        = 16'(item_i.c0[s]) * 16'(w_near);
      pb        = 16'(item_i.c1[s]) * 16'(item_i.t);
      sum       = {1'b0, pa} + {1'b0, pb};
      num1_d[s] = sum[15:0];
    end
  end

  // Stage 2: estimate the quotient, low by at most one
  always_comb begin
    logic [40:0] prod;
    for (int s = 0; s < CHAN_N; s++) begin
      prod      = 41'(num1_q[s]) * 41'(recip1_q);
      q2_d[s]   = prod[RECIP_SHIFT +: 8];
      num2_d[s] = num1_q[s];
    end
  end

  // Stage 3: remainder of the estimate
  always_comb begin
    logic [15:0] qd, diff;
    for (int s = 0; s < CHAN_N; s++) begin
      qd      = 16'(q2_q[s]) * 16'(d2_q);
      diff    = num2_q[s] - qd;
      r3_d[s] = diff[8:0];
      q3_d[s] = q2_q[s];
    end
  end

  // Stage 4: correct the quotient so that the remainder is below the span
  always_comb begin
    logic [8:0] rr;
    for (int s = 0; s < CHAN_N; s++) begin
      if (r3_q[s] >= {1'b0, d3_q}) begin
        rr      = r3_q[s] - {1'b0, d3_q};
        q4_d[s] = q3_q[s] + 8'd1;
      end else begin
        rr      = r3_q[s];
        q4_d[s] = q3_q[s];
      end
      r4_d[s] = rr[7:0];
    end
  end

  // Stage 5: round to nearest, ties to even
  always_comb begin
    logic [8:0] twice, span;
    logic       up;
    span = {1'b0, d4_q};
    for (int s = 0; s < CHAN_N; s++) begin
      twice   = {r4_q[s], 1'b0};
      up      = (twice > span) || ((twice == span) && q4_q[s][0]);
      q5_d[s] = q4_q[s] + 8'(up);
    end
  end

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk_i) begin
    num1_q   <= num1_d;
    recip1_q <= recip1_d;
    d1_q     <= item_i.d;
    b1_q     <= item_i.beyond;

    num2_q   <= num2_d;
    q2_q     <= q2_d;
    d2_q     <= d1_q;
    b2_q     <= b1_q;

    r3_q     <= r3_d;
    q3_q     <= q3_d;
    d3_q     <= d2_q;
    b3_q     <= b2_q;

    r4_q     <= r4_d;
    q4_q     <= q4_d;
    d4_q     <= d3_q;
    b4_q     <= b3_q;

    q5_q     <= q5_d;
    b5_q     <= b4_q;
  end

  assign valid_o  = v5_q;
  assign red_o    = q5_q[0];
  assign green_o  = q5_q[1];
  assign blue_o   = q5_q[2];
  assign beyond_o = b5_q;

endmodule

FILE: verif/colour_ramp_checker.sv
// ---------------------------------------------------------------------------
// colour_ramp_checker: prediction and scoreboard for the colour ramp
// Tracks knot register beats, works out the colour of every level taken by
// the block and compares each result beat field by field in arrival order.
// ---------------------------------------------------------------------------
module colour_ramp_checker import plcr_pkg::*; #(
  parameter int LEVEL_COUNT = 256,
  parameter int KNOT_COUNT  = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_o,
  input  logic [7:0]           level_i,
  input  logic                 valid_o,
  input  logic [7:0]           red_o,
  input  logic [7:0]           green_o,
  input  logic [7:0]           blue_o,
  input  logic [7:0]           alpha_o,
  input  logic                 beyond_last_o,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          pending_count_o,
  output int unsigned          checked_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       beyond;
  } colour_t;

  logic [31:0] knot_word [KNOT_SLOTS];
  colour_t     colour_q [$];
  colour_t     want;
  colour_t     got;

  // Knot 0 always sits at position 0 whatever its register holds
  function automatic int knot_position(input int k);
    if (k == 0) return 0;
    return int'(knot_word[k][POS_LSB +: 8]);
  endfunction

  // Channel 0 is red, 1 green, 2 blue
  function automatic int knot_channel(input int k, input int ch);
    return int'(knot_word[k][16 - 8 * ch +: 8]);
  endfunction

  // (c0*(d-t) + c1*t) / d, rounded to nearest with ties to even
  function automatic logic [7:0] blend_channel(input int c0, input int c1,
                                               input int t, input int d);
    int num;
    int q;
    int r;
    num = c0 * (d - t) + c1 * t;
    q   = num / d;
    r   = num % d;
    if (2 * r > d || (2 * r == d && (q % 2) == 1)) q++;
    return q[7:0];
  endfunction

  function automatic colour_t ramp_colour(input logic [7:0] level);
    int      n;
    int      lvl;
    int      k;
    int      p0;
    int      p1;
    colour_t c;
    n = KNOT_COUNT;
    if (n < 2) n = 2;
    if (n > KNOT_SLOTS) n = KNOT_SLOTS;
    lvl = int'(level);
    if (lvl >= LEVEL_COUNT) lvl = LEVEL_COUNT - 1;
    // Pick the highest knot not above the level
    k = n - 1;
    while (k > 0 && knot_position(k) > lvl) k--;
    p0       = knot_position(k);
    c.red    = 8'(knot_channel(k, 0));
    c.green  = 8'(knot_channel(k, 1));
    c.blue   = 8'(knot_channel(k, 2));
    c.alpha  = ALPHA_OPAQUE;
    c.beyond = 1'b0;
    if (lvl != p0) begin
      if (k == n - 1) begin
        c.beyond = 1'b1;
      end else begin
        p1      = knot_position(k + 1);
        c.red   = blend_channel(knot_channel(k, 0), knot_channel(k + 1, 0),
                                lvl - p0, p1 - p0);
        c.green = blend_channel(knot_channel(k, 1), knot_channel(k + 1, 1),
                                lvl - p0, p1 - p0);
        c.blue  = blend_channel(knot_channel(k, 2), knot_channel(k + 1, 2),
                                lvl - p0, p1 - p0);
      end
    end
    return c;
  endfunction

  task automatic note_failure(input string what);
    mismatch_count_o++;
    if (mismatch_count_o <= REPORT_LIMIT)
      $display({"[%0t] %s: expected r=%02h g=%02h b=%02h a=%02h beyond=%0b,",
                " got r=%02h g=%02h b=%02h a=%02h beyond=%0b"},
               $time, what, want.red, want.green, want.blue, want.alpha,
               want.beyond, got.red, got.green, got.blue, got.alpha, got.beyond);
  endtask

  // Track knots, score result beats, then queue the colour of a taken level
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KNOT_SLOTS; i++) knot_word[i] = KNOT_RESET[i];
      colour_q.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
      checked_count_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o && cfg_index_i < KNOT_REGS)
        knot_word[cfg_index_i] = cfg_data_i;
      if (valid_o) begin
        got = '{red_o, green_o, blue_o, alpha_o, beyond_last_o};
        if (colour_q.size() == 0) begin
          want = '0;
          note_failure("colour beat with nothing outstanding");
        end else begin
          want = colour_q.pop_front();
          checked_count_o++;
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.alpha !== want.alpha ||
              got.beyond !== want.beyond)
            note_failure("colour mismatch");
        end
      end
      if (start_i && !busy_o) colour_q.push_back(ramp_colour(level_i));
      pending_count_o = colour_q.size();
    end
  end

endmodule

FILE: verif/piecewise_linear_color_ramp_top_tb.sv
// ---------------------------------------------------------------------------
// piecewise_linear_color_ramp_top_tb: level stream and knot programming
// Drives directed levels on the default and an irregular ramp, then random
// levels over a series of knot settings with varying start gaps; the
// checker beside the block scores every colour beat.
// ---------------------------------------------------------------------------
module piecewise_linear_color_ramp_top_tb import plcr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVEL_COUNT     = 256;
  localparam int KNOT_COUNT      = 6;
  localparam int PHASES          = 8;
  localparam int LEVELS_PER_PHASE = 228;
  localparam int DRAIN_LIMIT     = 200;

  typedef enum int {
    RAMP_ASCENDING,
    RAMP_TIGHT,
    RAMP_SCRAMBLED,
    RAMP_ZERO,
    RAMP_FULL
  } ramp_style_e;

  localparam ramp_style_e PHASE_STYLE [PHASES] = '{
    RAMP_ZERO, RAMP_ASCENDING, RAMP_FULL, RAMP_SCRAMBLED,
    RAMP_TIGHT, RAMP_ASCENDING, RAMP_SCRAMBLED, RAMP_ASCENDING
  };

  // Percent chance of a start gap per cycle, cycled over the phases
  localparam int GAP_PCT [4] = '{0, 84, 0, 32};

  // Default ramp: knots, neighbours, a tie and both ends
  localparam logic [7:0] DEFAULT_LEVELS [13] = '{
    8'd0, 8'd255, 8'd40, 8'd20, 8'd39, 8'd41, 8'd56, 8'd72,
    8'd128, 8'd127, 8'h55, 8'hAA, 8'd254
  };

  // Irregular ramp: knot 0 position set, knots 1 and 2 out of order,
  // last knot below the top so the upper levels run past it
  localparam logic [31:0] IRREGULAR_RAMP [KNOT_REGS] = '{
    32'hC012_3456, 32'h1080_40C0, 32'h0800_03FF,
    32'h3001_0000, 32'h50FF_FF00, 32'hF0AA_55AA
  };
  localparam logic [7:0] IRREGULAR_LEVELS [12] = '{
    8'd0, 8'd4, 8'd8, 8'd12, 8'd16, 8'd28, 8'd48, 8'd80,
    8'd200, 8'd240, 8'd241, 8'd255
  };

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start_i     = 1'b0;
  logic [7:0]           level_i     = '0;
  logic                 cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i  = '0;
  logic                 busy_o;
  logic                 valid_o;
  logic [7:0]           red_o;
  logic [7:0]           green_o;
  logic [7:0]           blue_o;
  logic [7:0]           alpha_o;
  logic                 beyond_last_o;
  logic                 cfg_ready_o;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned checked_count;

  logic [31:0] ramp_img  [KNOT_REGS];
  logic [31:0] next_ramp [KNOT_REGS];
  int          levels_sent;
  int          reg_beats;
  int          settings;

  piecewise_linear_color_ramp_top #(
    .LEVEL_COUNT(LEVEL_COUNT),
    .KNOT_COUNT (KNOT_COUNT)
  ) uut (.*);

  colour_ramp_checker #(
    .LEVEL_COUNT(LEVEL_COUNT),
    .KNOT_COUNT (KNOT_COUNT)
  ) checker_i (
    .*,
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count),
    .checked_count_o (checked_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop for a hung run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Present one level and hold start until the beat is taken; maybe gap after
  task automatic send_level(input logic [7:0] lv, input int gap_pct);
    start_i <= 1'b1;
    level_i <= lv;
    do @(posedge clk_i); while (busy_o);
    levels_sent++;
    if ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
  endtask

  // One register beat; valid stays high for a following beat
  task automatic write_beat(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < KNOT_REGS) ramp_img[idx] = data;
    reg_beats++;
  endtask

  // Load next_ramp into all knots, with the odd beat past the knot file
  task automatic program_ramp();
    for (int i = 0; i < KNOT_REGS; i++) begin
      write_beat(CFG_IDX_W'(i), next_ramp[i]);
      if ($urandom_range(3) == 0)
        write_beat(CFG_IDX_W'(KNOT_REGS + $urandom_range(1)), $urandom());
    end
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  // Wait until every colour has come back, then realign to a rising edge
  task automatic drain_results();
    int guard;
    guard = 0;
    do begin
      @(negedge clk_i);
      guard++;
    end while (pending_count != 0 && guard < DRAIN_LIMIT);
    @(posedge clk_i);
  endtask

  function automatic logic [23:0] random_rgb();
    logic [23:0] rgb;
    for (int ch = 0; ch < CHAN_N; ch++) begin
      case ($urandom_range(9))
        0:       rgb[8 * ch +: 8] = 8'h00;
        1:       rgb[8 * ch +: 8] = 8'hFF;
        default: rgb[8 * ch +: 8] = 8'($urandom());
      endcase
    end
    return rgb;
  endfunction

  task automatic make_ramp(input ramp_style_e style);
    int pos;
    int room;
    int step_max;
    case (style)
      RAMP_ASCENDING: begin
        pos = 0;
        next_ramp[0] = {8'($urandom()), random_rgb()};
        for (int i = 1; i < KNOT_REGS; i++) begin
          room     = 255 - pos - (KNOT_REGS - 1 - i);
          step_max = 2 * (255 - pos) / (KNOT_REGS - i);
          if (step_max > room) step_max = room;
          if (step_max < 1) step_max = 1;
          pos += $urandom_range(step_max, 1);
          next_ramp[i] = {8'(pos), random_rgb()};
        end
        if ($urandom_range(1) == 1) next_ramp[KNOT_REGS - 1][POS_LSB +: 8] = 8'hFF;
      end
      RAMP_TIGHT: begin
        pos = $urandom_range(200);
        next_ramp[0] = {8'($urandom()), random_rgb()};
        for (int i = 1; i < KNOT_REGS; i++) begin
          pos += $urandom_range(2, 1);
          next_ramp[i] = {8'(pos), random_rgb()};
        end
      end
      RAMP_SCRAMBLED: for (int i = 0; i < KNOT_REGS; i++) next_ramp[i] = $urandom();
      RAMP_ZERO:      for (int i = 0; i < KNOT_REGS; i++) next_ramp[i] = '0;
      default:        for (int i = 0; i < KNOT_REGS; i++) next_ramp[i] = '1;
    endcase
  endtask

  // Bias towards knot positions and their neighbours, then the ends
  function automatic logic [7:0] pick_level();
    int          sel;
    int          k;
    logic [7:0]  p;
    sel = $urandom_range(99);
    if (sel < 35) begin
      k = $urandom_range(KNOT_REGS - 1);
      p = (k == 0) ? 8'd0 : ramp_img[k][POS_LSB +: 8];
      return p + 8'($urandom_range(2)) - 8'd1;
    end
    if (sel < 45) return ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
    return 8'($urandom());
  endfunction

  initial begin
    levels_sent = 0;
    reg_beats   = 0;
    settings    = 1;
    for (int i = 0; i < KNOT_REGS; i++) ramp_img[i] = KNOT_RESET[i];

    // Hold reset, then release on an edge
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default ramp
    foreach (DEFAULT_LEVELS[i]) send_level(DEFAULT_LEVELS[i], 0);
    start_i <= 1'b0;
    drain_results();

    // Irregular ramp, preceded by a beat to a register that does not exist
    write_beat(CFG_IDX_W'(KNOT_SLOTS - 1), 32'h5A5A_A5A5);
    foreach (IRREGULAR_RAMP[i]) next_ramp[i] = IRREGULAR_RAMP[i];
    program_ramp();
    foreach (IRREGULAR_LEVELS[i]) send_level(IRREGULAR_LEVELS[i], 0);
    start_i <= 1'b0;
    drain_results();

    // Random levels over a series of knot settings
    for (int ph = 0; ph < PHASES; ph++) begin
      make_ramp(PHASE_STYLE[ph]);
      program_ramp();
      for (int n = 0; n < LEVELS_PER_PHASE; n++) send_level(pick_level(), GAP_PCT[ph % 4]);
      start_i <= 1'b0;
      drain_results();
    end

    // Let any stray beat show up before the verdict
    repeat (10) @(posedge clk_i);

    $display("Checked %0d colours from %0d levels over %0d knot settings (%0d register beats).",
             checked_count, levels_sent, settings, reg_beats);
    $display({"Ramps: default, irregular, ascending, tight, scrambled, all-zero, all-one;",
              " starts gap-free and bursty."});
    if (pending_count != 0) $display("%0d colours never arrived", pending_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
